/* hdl/ptt_pkg.sv */
`timescale 1ns / 1ps
package ptt_pkg;

   localparam int KEY_W   = 64;
   localparam int TIME_W  = 48;
   localparam int SLOT_W  = 4;
   localparam int KIND_W  = 2;
   localparam int ACT_W   = 3;
   localparam int COUNT_W = 5;

   localparam logic [KIND_W-1:0] KIND_TOGGLE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd1;
   localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;
   localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd3;

   localparam logic [ACT_W-1:0] ACT_ENTERED    = 3'd0;
   localparam logic [ACT_W-1:0] ACT_EXITED     = 3'd1;
   localparam logic [ACT_W-1:0] ACT_FULL       = 3'd2;
   localparam logic [ACT_W-1:0] ACT_FOUND      = 3'd3;
   localparam logic [ACT_W-1:0] ACT_NOT_FOUND  = 3'd4;
   localparam logic [ACT_W-1:0] ACT_SLOT_DATA  = 3'd5;
   localparam logic [ACT_W-1:0] ACT_SLOT_EMPTY = 3'd6;
   localparam logic [ACT_W-1:0] ACT_INVALID    = 3'd7;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [KEY_W-1:0]  card_key;
      logic [TIME_W-1:0] event_time;
      logic [SLOT_W-1:0] slot;
   } req_type;

   typedef struct packed {
      logic [ACT_W-1:0]   action;
      logic [COUNT_W-1:0] present_count;
      logic [KEY_W-1:0]   slot_key;
      logic [TIME_W-1:0]  slot_time;
   } rsp_type;

   typedef enum logic [2:0] {
      OP_TOGGLE,
      OP_LOOKUP,
      OP_READ,
      OP_CLEAR,
      OP_REJECT
   } op_code_type;

   typedef struct packed {
      op_code_type       code;
      logic [KEY_W-1:0]  key;
      logic [TIME_W-1:0] event_time;
      logic [SLOT_W-1:0] slot;
   } op_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

endpackage

/* hdl/ptt_front.sv */
`timescale 1ns / 1ps
module ptt_front #(
   parameter int KEY_BITS = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  ptt_pkg::req_type    req_item,
   input  ptt_pkg::q_stat_type q_stat,
   output logic                q_push,
   output ptt_pkg::op_type     q_data
);
   import ptt_pkg::*;

   logic   valid_ff, valid_in;
   op_type op_ff, op_in;
   logic   accept;
   logic [KEY_W-1:0] key_m;

   assign busy   = valid_ff & q_stat.full;
   assign accept = start & ~busy;
   assign q_push = valid_ff & ~q_stat.full;
   assign q_data = op_ff;
   assign key_m  = KEY_W'(req_item.card_key[KEY_BITS-1:0]);

   always_comb begin
      op_in            = op_ff;
      valid_in         = valid_ff & ~q_push;
      if (accept) begin
         valid_in         = 1'b1;
         op_in.key        = key_m;
         op_in.event_time = req_item.event_time;
         op_in.slot       = req_item.slot;
         unique case (req_item.kind)
            KIND_TOGGLE: op_in.code = (key_m == '0) ? OP_REJECT : OP_TOGGLE;
            KIND_LOOKUP: op_in.code = (key_m == '0) ? OP_REJECT : OP_LOOKUP;
            KIND_READ:   op_in.code = OP_READ;
            default:     op_in.code = OP_CLEAR;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

endmodule

/* hdl/ptt_queue.sv */
`timescale 1ns / 1ps
module ptt_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  ptt_pkg::op_type     push_data,
   input  logic                pop,
   output ptt_pkg::op_type     head,
   output ptt_pkg::q_stat_type stat
);
   import ptt_pkg::*;

   op_type     slots_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;

   assign head       = slots_ff[rd_ptr_ff];
   assign stat.full  = (fill_ff == 2'd2);
   assign stat.empty = (fill_ff == 2'd0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

/* hdl/ptt_back.sv */
`timescale 1ns / 1ps
module ptt_back #(
   parameter int ENTRY_DEPTH = 16,
   parameter int KEY_BITS    = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  ptt_pkg::op_type     q_head,
   input  ptt_pkg::q_stat_type q_stat,
   output logic                q_pop,
   output logic                rsp_valid,
   output ptt_pkg::rsp_type    rsp_item
);
   import ptt_pkg::*;

   localparam int CNT_W = $clog2(ENTRY_DEPTH + 1);
   localparam int IDX_W = (ENTRY_DEPTH > 1) ? $clog2(ENTRY_DEPTH) : 1;
   localparam int ENT_W = KEY_BITS + TIME_W;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SEARCH = 4'b0010,
      ST_SHIFT  = 4'b0100,
      ST_READ   = 4'b1000
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   op_type           op_ff, op_in;
   op_type           cur_op;
   logic [ENT_W-1:0] mem [ENTRY_DEPTH];
   logic [ENT_W-1:0] rd_q_ff;
   logic [CNT_W:0]   rd_addr_w;
   logic             wr_en;
   logic [IDX_W-1:0] wr_idx;
   logic [ENT_W-1:0] wr_data;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;
   logic             do_miss;
   logic [CNT_W:0]   idx_p1, idx_p2, count_x;
   logic [KEY_BITS-1:0] rd_key;

   function automatic logic [COUNT_W-1:0] cnt5(input logic [CNT_W-1:0] c);
      logic [31:0] w;
      w = 32'(c);
      return w[COUNT_W-1:0];
   endfunction

   assign rd_key    = rd_q_ff[ENT_W-1:TIME_W];
   assign idx_p1    = {1'b0, idx_ff} + (CNT_W+1)'(1);
   assign idx_p2    = {1'b0, idx_ff} + (CNT_W+1)'(2);
   assign count_x   = {1'b0, count_ff};
   assign cur_op    = (state_ff == ST_IDLE) ? q_head : op_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      op_in        = op_ff;
      q_pop        = 1'b0;
      wr_en        = 1'b0;
      wr_idx       = idx_ff[IDX_W-1:0];
      wr_data      = rd_q_ff;
      rd_addr_w    = idx_p1;
      do_miss      = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      rsp_in.present_count = cnt5(count_ff);

      unique case (state_ff)
         ST_IDLE: begin
            if (!q_stat.empty) begin
               q_pop = 1'b1;
               op_in = q_head;
               unique case (q_head.code)
                  OP_CLEAR: begin
                     count_in             = '0;
                     rsp_valid_in         = 1'b1;
                     rsp_in.action        = ACT_INVALID;
                     rsp_in.present_count = '0;
                  end
                  OP_READ: begin
                     if (32'(q_head.slot) < 32'(count_ff)) begin
                        rd_addr_w = (CNT_W+1)'(q_head.slot);
                        state_in  = ST_READ;
                     end else begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.action = ACT_SLOT_EMPTY;
                     end
                  end
                  OP_TOGGLE, OP_LOOKUP: begin
                     if (count_ff == '0) begin
                        do_miss = 1'b1;
                     end else begin
                        idx_in    = '0;
                        rd_addr_w = '0;
                        state_in  = ST_SEARCH;
                     end
                  end
                  default: begin
                     rsp_valid_in  = 1'b1;
                     rsp_in.action = ACT_INVALID;
                  end
               endcase
            end
         end
         ST_SEARCH: begin
            if (rd_key == op_ff.key[KEY_BITS-1:0]) begin
               if (op_ff.code == OP_LOOKUP) begin
                  rsp_valid_in  = 1'b1;
                  rsp_in.action = ACT_FOUND;
                  state_in      = ST_IDLE;
               end else if (idx_p1 == count_x) begin
                  count_in             = count_ff - CNT_W'(1);
                  rsp_valid_in         = 1'b1;
                  rsp_in.action        = ACT_EXITED;
                  rsp_in.present_count = cnt5(count_ff - CNT_W'(1));
                  state_in             = ST_IDLE;
               end else begin
                  state_in = ST_SHIFT;
               end
            end else if (idx_p1 == count_x) begin
               do_miss  = 1'b1;
               state_in = ST_IDLE;
            end else begin
               idx_in = idx_p1[CNT_W-1:0];
            end
         end
         ST_SHIFT: begin
            wr_en     = 1'b1;
            rd_addr_w = idx_p2;
            idx_in    = idx_p1[CNT_W-1:0];
            if (idx_p2 == count_x) begin
               count_in             = count_ff - CNT_W'(1);
               rsp_valid_in         = 1'b1;
               rsp_in.action        = ACT_EXITED;
               rsp_in.present_count = cnt5(count_ff - CNT_W'(1));
               state_in             = ST_IDLE;
            end
         end
         ST_READ: begin
            rsp_valid_in     = 1'b1;
            rsp_in.action    = ACT_SLOT_DATA;
            rsp_in.slot_key  = KEY_W'(rd_key);
            rsp_in.slot_time = rd_q_ff[TIME_W-1:0];
            state_in         = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (do_miss) begin
         rsp_valid_in = 1'b1;
         if (cur_op.code == OP_LOOKUP) begin
            rsp_in.action = ACT_NOT_FOUND;
         end else if (count_ff == CNT_W'(ENTRY_DEPTH)) begin
            rsp_in.action = ACT_FULL;
         end else begin
            wr_en                = 1'b1;
            wr_idx               = count_ff[IDX_W-1:0];
            wr_data              = {cur_op.key[KEY_BITS-1:0], cur_op.event_time};
            count_in             = count_ff + CNT_W'(1);
            rsp_in.action        = ACT_ENTERED;
            rsp_in.present_count = cnt5(count_ff + CNT_W'(1));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
      rd_q_ff <= mem[rd_addr_w[IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      idx_ff <= idx_in;
      rsp_ff <= rsp_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(ENTRY_DEPTH))
      else $error("entry count above table depth");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> state_ff == ST_IDLE)
      else $error("result issued while request still in progress");

   a_slot_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.action != ACT_SLOT_DATA) |->
      (rsp_ff.slot_key == '0 && rsp_ff.slot_time == '0))
      else $error("slot fields nonzero outside slot data");

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> !(state_ff == ST_IDLE && $past(state_ff) != ST_IDLE && rsp_valid_ff == 1'b0
      && $past(rsp_valid_in) == 1'b1))
      else $error("pop while result pending");
`endif

endmodule

/* hdl/presence_toggle_table.sv */
`timescale 1ns / 1ps
// The front end registers each request, the queue holds it and the back end registers
// the result. Clear, rejected key, empty slot read and toggle or lookup on an empty table
// answer from idle; a slot read also passes the table read register; a toggle or lookup
// searches one entry per cycle, and an exit then shifts later entries one per cycle. The
// back end pops a new request only when idle. Reset (synchronous, active high) empties the
// table; stored entries are not cleared. Results strobe rsp_valid; receiver cannot stall.
module presence_toggle_table #(
   parameter int ENTRY_DEPTH = 16,
   parameter int KEY_BITS    = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  ptt_pkg::req_type req_item,
   output logic             rsp_valid,
   output ptt_pkg::rsp_type rsp_item
);
   import ptt_pkg::*;

   op_type     q_in_data, q_head;
   q_stat_type q_stat;
   logic       q_push, q_pop;

   ptt_front #(
      .KEY_BITS(KEY_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_item (req_item),
      .q_stat   (q_stat),
      .q_push   (q_push),
      .q_data   (q_in_data)
   );

   ptt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in_data),
      .pop       (q_pop),
      .head      (q_head),
      .stat      (q_stat)
   );

   ptt_back #(
      .ENTRY_DEPTH(ENTRY_DEPTH),
      .KEY_BITS   (KEY_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_head    (q_head),
      .q_stat    (q_stat),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule

/* verif/presence_toggle_table_tb.sv */
`timescale 1ns / 1ps
module presence_toggle_table_tb;
   import ptt_pkg::*;

   localparam int ENTRY_DEPTH  = 16;
   localparam int POOL_SIZE    = 24;
   localparam int SEGMENTS     = 14;
   localparam int SEG_ITEMS    = 102;
   localparam int DRAIN_CYCLES = 48;
   localparam int CYCLE_LIMIT  = 600000;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   logic    rsp_valid;
   req_type req_item;
   rsp_type rsp_item;

   // table model
   logic [KEY_W-1:0]  table_keys [ENTRY_DEPTH];
   logic [TIME_W-1:0] table_times [ENTRY_DEPTH];
   int                table_count = 0;

   rsp_type           pending_answers [$];
   logic [KEY_W-1:0]  key_pool [POOL_SIZE];
   int                fail_count = 0;
   int                cycle_count = 0;
   bit                no_idle = 1'b0;

   presence_toggle_table #(
      .ENTRY_DEPTH(ENTRY_DEPTH),
      .KEY_BITS(KEY_W)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_item(req_item),
      .rsp_valid(rsp_valid),
      .rsp_item(rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int find_entry(logic [KEY_W-1:0] key);
      for (int i = 0; i < table_count; i++) begin
         if (table_keys[i] == key) return i;
      end
      return -1;
   endfunction

   function automatic rsp_type apply_request(req_type r);
      rsp_type a;
      int      pos;
      a = '0;
      a.action = ACT_INVALID;
      case (r.kind)
         KIND_TOGGLE: begin
            if (r.card_key != '0) begin
               pos = find_entry(r.card_key);
               if (pos >= 0) begin
                  for (int i = pos; i + 1 < table_count; i++) begin
                     table_keys[i]  = table_keys[i + 1];
                     table_times[i] = table_times[i + 1];
                  end
                  table_count--;
                  a.action = ACT_EXITED;
               end else if (table_count >= ENTRY_DEPTH) begin
                  a.action = ACT_FULL;
               end else begin
                  table_keys[table_count]  = r.card_key;
                  table_times[table_count] = r.event_time;
                  table_count++;
                  a.action = ACT_ENTERED;
               end
            end
         end
         KIND_LOOKUP: begin
            if (r.card_key != '0)
               a.action = (find_entry(r.card_key) >= 0) ? ACT_FOUND : ACT_NOT_FOUND;
         end
         KIND_READ: begin
            if (int'(r.slot) < table_count) begin
               a.action    = ACT_SLOT_DATA;
               a.slot_key  = table_keys[r.slot];
               a.slot_time = table_times[r.slot];
            end else begin
               a.action = ACT_SLOT_EMPTY;
            end
         end
         default: begin
            table_count = 0;
            for (int i = 0; i < ENTRY_DEPTH; i++) begin
               table_keys[i]  = '0;
               table_times[i] = '0;
            end
         end
      endcase
      a.present_count = COUNT_W'(table_count);
      return a;
   endfunction

   function automatic req_type make_req(logic [KIND_W-1:0] kind, logic [KEY_W-1:0] key);
      req_type r;
      r.kind       = kind;
      r.card_key   = key;
      r.event_time = TIME_W'({$urandom, $urandom});
      r.slot       = SLOT_W'($urandom_range(0, 15));
      return r;
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (no_idle || roll < 50) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   task automatic send_request(req_type r);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_answers.push_back(apply_request(r));
   endtask

   // sender holds off until every answer is back
   task automatic wait_drained();
      start <= 1'b0;
      do @(posedge clock); while (pending_answers.size() != 0);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_answers.size() == 0) begin
            $display("%0t: result expected none actual %p", $time, rsp_item);
            fail_count++;
         end else begin
            want = pending_answers.pop_front();
            if (rsp_item.action !== want.action) begin
               $display("%0t: action expected %0d actual %0d",
                        $time, want.action, rsp_item.action);
               fail_count++;
            end
            if (rsp_item.present_count !== want.present_count) begin
               $display("%0t: present_count expected %0d actual %0d",
                        $time, want.present_count, rsp_item.present_count);
               fail_count++;
            end
            if (rsp_item.slot_key !== want.slot_key) begin
               $display("%0t: slot_key expected %h actual %h",
                        $time, want.slot_key, rsp_item.slot_key);
               fail_count++;
            end
            if (rsp_item.slot_time !== want.slot_time) begin
               $display("%0t: slot_time expected %h actual %h",
                        $time, want.slot_time, rsp_item.slot_time);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d results outstanding", $time, pending_answers.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic test_empty_table();
      req_type r;
      r = make_req(KIND_READ, '0);
      r.slot = '0;
      send_request(r);
      r = make_req(KIND_READ, '1);
      r.slot = '1;
      send_request(r);
      send_request(make_req(KIND_LOOKUP, key_pool[1]));
      r = make_req(KIND_TOGGLE, '0);
      r.event_time = '1;
      send_request(r);
      send_request(make_req(KIND_LOOKUP, '0));
      wait_drained();
   endtask

   task automatic test_fill_to_full();
      req_type r;
      for (int i = 0; i < ENTRY_DEPTH; i++) begin
         r = make_req(KIND_TOGGLE, key_pool[i]);
         if (i == 0) r.event_time = '1;
         if (i == 1) r.event_time = '0;
         send_request(r);
      end
      send_request(make_req(KIND_TOGGLE, key_pool[ENTRY_DEPTH]));
      send_request(make_req(KIND_LOOKUP, key_pool[5]));
      r = make_req(KIND_READ, '0);
      r.slot = '1;
      send_request(r);
      // exit of the oldest entry shifts the whole table
      send_request(make_req(KIND_TOGGLE, key_pool[0]));
      send_request(make_req(KIND_LOOKUP, key_pool[0]));
      send_request(make_req(KIND_CLEAR, '1));
      wait_drained();
   endtask

   task automatic test_random_traffic();
      int               enter_bias;
      int               span;
      int               roll;
      int               base;
      logic [KEY_W-1:0] key;
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         case ($urandom_range(0, 3))
            0: enter_bias = 20;
            1: enter_bias = 50;
            2: enter_bias = 90;
            default: enter_bias = 100;
         endcase
         span    = $urandom_range(4, POOL_SIZE);
         no_idle = ($urandom_range(0, 3) == 0);
         if (seg % 4 == 3) wait_drained();
         for (int n = 0; n < SEG_ITEMS; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 60) begin
               if ($urandom_range(0, 99) < 5) begin
                  key = ($urandom_range(0, 1) == 0) ? '0 : {$urandom, $urandom};
               end else if ($urandom_range(0, 99) < enter_bias || table_count == 0) begin
                  key  = {$urandom, $urandom};
                  base = $urandom_range(0, span - 1);
                  for (int j = 0; j < span; j++) begin
                     if (find_entry(key_pool[(base + j) % span]) < 0) begin
                        key = key_pool[(base + j) % span];
                        break;
                     end
                  end
               end else begin
                  key = table_keys[$urandom_range(0, table_count - 1)];
               end
               send_request(make_req(KIND_TOGGLE, key));
            end else if (roll < 78) begin
               case ($urandom_range(0, 9))
                  0: key = '0;
                  1, 2, 3: key = {$urandom, $urandom};
                  default: key = key_pool[$urandom_range(0, span - 1)];
               endcase
               send_request(make_req(KIND_LOOKUP, key));
            end else if (roll < 98) begin
               send_request(make_req(KIND_READ, {$urandom, $urandom}));
            end else begin
               send_request(make_req(KIND_CLEAR, {$urandom, $urandom}));
            end
         end
      end
      no_idle = 1'b0;
   endtask

   initial begin
      reset    = 1'b1;
      start    = 1'b0;
      req_item = '0;
      key_pool[0] = '1;
      key_pool[1] = 64'd1;
      key_pool[2] = {1'b1, {(KEY_W - 1){1'b0}}};
      for (int i = 3; i < POOL_SIZE; i++) begin
         key_pool[i] = {$urandom, $urandom};
         key_pool[i][4:0] = 5'(i);
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_empty_table();
      test_fill_to_full();
      test_random_traffic();

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
